[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the sharpen filter.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// When pre holds, post holds at the next clock edge.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle property");

`endif

[hdl/rsf_pkg.sv]
// Package of the RGB 3x3 sharpen filter: sizes, reset values, register
// indexes, pixel type and the per-channel kernel arithmetic. No dependencies.
package rsf_pkg;

  localparam int RSF_MAX_WIDTH = 2048;
  localparam int DIM_W         = 12;
  localparam int ROW_W         = 13;
  localparam int PIX_W         = 24;
  localparam int CHAN_W        = 8;
  localparam int DIM_MIN       = 3;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  typedef logic [PIX_W-1:0] rsf_pixel_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } rsf_reg_t;

  // Center weight ten, eight neighbors minus one, clamped to 0..255.
  function automatic logic [CHAN_W-1:0] rsf_sharpen(input logic [CHAN_W-1:0] ctr,
                                                    input logic [10:0] nsum);
    logic signed [13:0] acc;
    logic [CHAN_W-1:0]  res;
    acc = $signed({3'b000, ctr, 3'b000}) + $signed({5'b00000, ctr, 1'b0})
        - $signed({3'b000, nsum});
    if (acc < 14'sd0) begin
      res = 8'd0;
    end else if (acc > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

endpackage

[hdl/rsf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rsf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/rgb_sharpen_3x3_filter.sv]
// RGB 3x3 sharpen filter, top level. Uses rsf_pkg, rsf_ram and assert_macros.svh.
// Holds the counters, the 3x3 window, the output stages and the APB registers.
//
// The filter takes one word per clock, pixel or drain tick, for as long as the
// output side keeps up; a stall on the output reaches back to in_stall in the
// same cycle once the two output stages are full. The two previous lines sit in
// one RAM entry per column, read ahead at the next column and written back as
// the word is taken, so the RAM gives the one-word-per-clock figure.
// A result is held in the result stage, then the output stage; results
// trail the input by one line plus one pixel: after the last pixel of a frame,
// give frame_width+1 drain ticks before the next frame. Border pixels pass
// through unchanged. Writing either register abandons the frame in progress.
module rgb_sharpen_3x3_filter
  import rsf_pkg::*;
#(
  parameter int MAX_WIDTH = RSF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 2);

  logic [DIM_W-1:0] fw_r, fh_r;
  logic [WW-1:0]    eff_w;
  logic [DIM_W-1:0] eff_h;
  logic             cfg_wr;
  rsf_reg_t         cfg_sel;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]    pend_r, pend_nxt;

  rsf_pixel_t       win_r [9];
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata, fwd_data_r, line_rd;
  logic             fwd_r;

  logic             receiving, is_pixel, in_acc, adv, emit, wrap, border, last;
  rsf_pixel_t       px;
  logic [ROW_W-1:0] o_r, h_m1;
  logic [WW-1:0]    o_c, col_inc;

  logic             s1_valid_r, s1_valid_nxt, s1_border_r, s1_last_r, s1_move;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       chan_out [3];
  logic [10:0]      nsum [3];
  logic [7:0]       out_red_r, out_green_r, out_blue_r;
  logic             out_last_r;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = rsf_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RESET;
      fh_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  fw_r <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (fw_r < DIM_W'(DIM_MIN)) begin
      eff_w = WW'(DIM_MIN);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_r);
    end
    eff_h = (fh_r < DIM_W'(DIM_MIN)) ? DIM_W'(DIM_MIN) : fh_r;
  end

  // Input decode and output position of the word being taken.
  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  assign receiving = row_r < ROW_W'(eff_h);
  assign is_pixel  = receiving && !in_cmd;
  assign adv       = in_acc && (is_pixel || (pend_r != '0));
  assign emit      = adv && (!receiving || (pend_r >= eff_w + WW'(1)));
  assign px        = is_pixel ? {in_red, in_green, in_blue} : '0;

  assign col_inc = WW'(col_r) + WW'(1);
  assign wrap    = col_inc >= eff_w;
  assign h_m1    = ROW_W'(eff_h) - ROW_W'(1);

  always_comb begin
    if (col_r != '0) begin
      o_r = row_r - ROW_W'(1);
      o_c = WW'(col_r) - WW'(1);
    end else begin
      o_r = row_r - ROW_W'(2);
      o_c = eff_w - WW'(1);
    end
    border = (o_r == '0) || (o_r >= h_m1) || (o_c == '0) || (o_c >= eff_w - WW'(1));
    last   = (o_r == h_m1) && (o_c == eff_w - WW'(1));
  end

  // Counters.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cfg_wr || (emit && last)) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (adv) begin
      col_nxt = wrap ? '0 : col_inc[CW-1:0];
      row_nxt = wrap ? row_r + ROW_W'(1) : row_r;
      if (!receiving) begin
        pend_nxt = pend_r - WW'(1);
      end else if (!emit) begin
        pend_nxt = pend_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Line store: upper half is two lines up, lower half one line up.
  assign ram_wdata = {line_rd[PIX_W-1:0], px};

  rsf_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (col_nxt),
    .rdata (ram_rdata)
  );

  // A write to the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= adv && (col_r == col_nxt);
    end
    fwd_data_r <= ram_wdata;
  end

  assign line_rd = fwd_r ? fwd_data_r : ram_rdata;

  // 3x3 window, rows oldest first, columns left to right.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3+1];
        win_r[r*3+1]   <= win_r[r*3+2];
      end
      win_r[2] <= line_rd[2*PIX_W-1:PIX_W];
      win_r[5] <= line_rd[PIX_W-1:0];
      win_r[8] <= px;
    end
  end

  // Result stage: flags captured with the word, kernel evaluated from the registered window.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      nsum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          nsum[ch] = nsum[ch] + 11'(win_r[k][(2-ch)*CHAN_W +: CHAN_W]);
        end
      end
      chan_out[ch] = s1_border_r ? win_r[4][(2-ch)*CHAN_W +: CHAN_W]
                                 : rsf_sharpen(win_r[4][(2-ch)*CHAN_W +: CHAN_W], nsum[ch]);
    end
  end

  always_comb begin
    if (emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_valid_r && s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_border_r <= border;
      s1_last_r   <= last;
    end
    if (s1_valid_r && s1_move) begin
      out_red_r   <= chan_out[0];
      out_green_r <= chan_out[1];
      out_blue_r  <= chan_out[2];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_frame_last = out_last_r;

  `ASSERT_ALWAYS(a_col_in_row, WW'(col_r) < eff_w)
  `ASSERT_ALWAYS(a_pend_bound, pend_r <= eff_w + WW'(1))
  `ASSERT_NEXT(a_last_clears, emit && last, (col_r == '0) && (row_r == '0) && (pend_r == '0))
  `ASSERT_NEXT(a_result_lands, emit, s1_valid_r)

endmodule
